/* hdl/assert_macros.svh */
// Assertion macros used by the oscillator back part.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

/* hdl/pbo_pkg.sv */
// Package for the PolyBLEP oscillator: widths, codes, sine table function.
// Depends on nothing.
package pbo_pkg;
    localparam int PhaseBits = 24;
    localparam int OutBits   = 16;
    localparam int FracBits  = OutBits - 1;
    localparam int TabDepth  = 1024;
    localparam int TabBits   = 10;
    localparam int GainBits  = 16;
    localparam int RatioBits = 30;
    localparam int QDepth    = 2;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_SQUARE = 2'd2,
        WAVE_NONE   = 2'd3
    } wave_t;

    // Work item handed from the front part to the back part.
    typedef struct packed {
        logic [PhaseBits-1:0] phase;
        logic [PhaseBits-1:0] step;
        logic [GainBits-1:0]  gain;
        wave_t                wave;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_MUL,
        ST_OUT
    } bk_state_t;

    // Eight-term Taylor sine in Q1.30, clamped to [0, 1].
    function automatic logic [30:0] sin_q30(input logic [63:0] x);
        logic signed [63:0] sum;
        logic [63:0] term;
        sum  = $signed(x);
        term = x;
        for (int k = 1; k <= 7; k++) begin
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > 64'sd1073741824)
            sum = 64'sd1073741824;
        return sum[30:0];
    endfunction

    // Table row i: sin(pi/2 * i / depth) rounded to the wave format.
    function automatic logic [FracBits:0] sine_row(input logic [TabBits:0] i);
        logic [63:0] s;
        logic [63:0] v;
        s = 64'(sin_q30((64'd1686629713 * 64'(i)) / 64'(TabDepth)));
        v = (s + (64'd1 << (29 - FracBits))) >> (30 - FracBits);
        if (v > (64'd1 << FracBits))
            v = 64'd1 << FracBits;
        return v[FracBits:0];
    endfunction
endpackage

/* hdl/pbo_front.sv */
// Front part: accepts ticks, clamps the step, advances the phase accumulator.
// Depends on pbo_pkg.
module pbo_front
    import pbo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [PhaseBits-1:0] phase_step,
    input  logic [GainBits-1:0]  gain,
    input  wave_t                wave,
    output logic                 job_valid,
    input  logic                 job_ready,
    output job_t                 job
);
    logic [PhaseBits-1:0] phase_reg, phase_next;
    logic [PhaseBits-1:0] step_sat;
    logic                 take;

    localparam logic [PhaseBits-1:0] Half = PhaseBits'(1) << (PhaseBits - 1);

    // Clamp step to one half.
    assign step_sat  = (phase_step > Half) ? Half : phase_step;
    assign full      = !job_ready;
    assign take      = push && job_ready;
    assign job_valid = push;
    assign job.phase = phase_reg;
    assign job.step  = step_sat;
    assign job.gain  = gain;
    assign job.wave  = wave;
    assign phase_next = take ? phase_reg + step_sat : phase_reg;

    // Hold accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else
            phase_reg <= phase_next;
    end
endmodule

/* hdl/pbo_queue.sv */
// Short queue between front and back parts.
// Depends on pbo_pkg.
module pbo_queue
    import pbo_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);
    job_t       mem_reg [QDepth];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 2'(QDepth);
    assign rd_valid = cnt_reg != 2'd0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    // Store entry.
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    // Advance pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end
endmodule

/* hdl/pbo_div.sv */
// Restoring divider: quotient = floor(num * 2^30 / den), one bit per cycle.
// Depends on pbo_pkg.
module pbo_div
    import pbo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [PhaseBits-1:0] num,
    input  logic [PhaseBits-1:0] den,
    output logic                 done,
    output logic [RatioBits:0]   quo
);
    localparam int CntBits = 5;
    logic [PhaseBits:0]    rem_reg, rem_next;
    logic [PhaseBits:0]    trial;
    logic [RatioBits:0]    quo_reg, quo_next;
    logic [CntBits:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    assign quo   = quo_reg;
    assign done  = done_reg;
    assign trial = {rem_reg[PhaseBits-1:0], 1'b0} - {1'b0, den};

    // num < den is required of the caller and not checked here; the integer part is then zero; 30 fraction bits.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {1'b0, num};
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[PhaseBits])
            begin
                rem_next = trial;
                quo_next = {quo_reg[RatioBits-1:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[PhaseBits-1:0], 1'b0};
                quo_next = {quo_reg[RatioBits-1:0], 1'b0};
            end
            cnt_next = cnt_reg + (CntBits+1)'(1);
            if (cnt_reg == (CntBits+1)'(RatioBits - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end
endmodule

/* hdl/pbo_back.sv */
// Back part: waveform, PolyBLEP corrections, gain and saturation; output register.
// Depends on pbo_pkg, pbo_div, assert_macros.svh.
`include "assert_macros.svh"
module pbo_back
    import pbo_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_valid,
    output logic                      job_ready,
    input  job_t                      job,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [OutBits-1:0] sample
);
    localparam logic [PhaseBits-1:0] Half = PhaseBits'(1) << (PhaseBits - 1);
    localparam int WBits = FracBits + 3;
    localparam logic signed [WBits-1:0] WOne = WBits'(1) << FracBits;
    localparam int PBits = WBits + GainBits + 1;
    localparam int RomDepth = TabDepth + 1;

    bk_state_t state_reg, state_next;
    job_t      job_reg;
    logic signed [WBits-1:0] w_reg, w_next;
    logic signed [OutBits-1:0] out_reg, out_next;
    logic      out_full_reg, out_full_next;
    logic      load;

    // Divider interface.
    logic                 div_start, div_done;
    logic [PhaseBits-1:0] div_num;
    logic [RatioBits:0]   div_quo;
    logic [PhaseBits-1:0] n1, n2;
    logic                 a1, g1, a2, g2;
    logic [PhaseBits-1:0] t2;

    // Quarter-wave sine table, read with a registered output.
    logic [FracBits:0]       sine_rom [RomDepth];
    logic [FracBits:0]       rom_q_reg;
    logic [1:0]              quad;
    logic [TabBits:0]        row;
    logic signed [WBits-1:0] sine_val;

    // Correction classification for a phase: active, negative side, numerator.
    function automatic logic [PhaseBits+1:0] classify(input logic [PhaseBits-1:0] t,
                                                     input logic [PhaseBits-1:0] dt);
        logic [PhaseBits:0] sum;
        sum = {1'b0, t} + {1'b0, dt};
        if (dt == '0)
            return '0;
        if (t < dt)
            return {1'b1, 1'b1, t};
        if (sum > {1'b1, {PhaseBits{1'b0}}})
            return {1'b1, 1'b0, sum[PhaseBits-1:0]};
        return '0;
    endfunction

    // Square of the ratio (of one minus it, negated, on the negative side), rounded to the wave format.
    function automatic logic signed [WBits-1:0] corr(input logic [RatioBits:0] q,
                                                    input logic neg);
        logic [RatioBits:0] r;
        logic [61:0]        sq;
        logic [61:0]        v;
        r  = neg ? ((RatioBits+1)'(1) << RatioBits) - q : q;
        sq = 62'(r) * 62'(r);
        v  = (sq + (62'd1 << (59 - FracBits))) >> (60 - FracBits);
        return neg ? -$signed(WBits'(v)) : $signed(WBits'(v));
    endfunction

    // Fill the table with the constant rows.
    initial
    begin
        for (int i = 0; i < RomDepth; i++)
            sine_rom[i] = sine_row((TabBits+1)'(i));
    end

    // Pick the row from the quadrant offset; mirror odd quadrants.
    assign quad = job_reg.phase[PhaseBits-1 -: 2];
    assign row  = quad[0] ? (TabBits+1)'(TabDepth) - {1'b0, job_reg.phase[PhaseBits-3 -: TabBits]}
                          : {1'b0, job_reg.phase[PhaseBits-3 -: TabBits]};

    always_ff @(posedge clk)
    begin
        rom_q_reg <= sine_rom[row];
    end

    // Negate the lower half of the wave.
    assign sine_val = quad[1] ? -$signed(WBits'(rom_q_reg)) : $signed(WBits'(rom_q_reg));

    assign t2 = job_reg.phase + Half;
    assign {a1, g1, n1} = classify(job_reg.phase, job_reg.step);
    assign {a2, g2, n2} = classify(t2, job_reg.step);
    // First division starts on the start pulse, the second when the first ends.
    assign div_num = (state_reg == ST_DIV1 && !start_pulse_reg) ? n2 : n1;

    pbo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (job_reg.step),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign empty     = !out_full_reg;
    assign sample    = out_reg;
    assign job_ready = (state_reg == ST_IDLE);
    assign load      = job_valid && job_ready;

    // Sequence one item through the back part.
    logic signed [PBits-1:0] prod;
    logic signed [PBits-1:0] yq;
    assign prod = PBits'(w_reg) * PBits'($signed({1'b0, job_reg.gain})) + PBits'(2048);
    assign yq   = prod >>> 12;

    logic start_pulse_reg;
    always_comb
    begin
        state_next    = state_reg;
        w_next        = w_reg;
        out_next      = out_reg;
        out_full_next = out_full_reg;
        div_start     = 1'b0;
        if (pop && out_full_reg)
            out_full_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load)
                    state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (start_pulse_reg)
                begin
                    // Base waveform; sine waits for the table read to settle.
                    unique case (job_reg.wave)
                        WAVE_SAW:    w_next = $signed(WBits'({job_reg.phase[PhaseBits-1 -: FracBits], 1'b0}))
                                              - WOne;
                        WAVE_SQUARE: w_next = job_reg.phase[PhaseBits-1] ? -WOne : WOne;
                        default:     w_next = '0;
                    endcase
                    div_start = 1'b1;
                end
                else if (div_done)
                begin
                    if (job_reg.wave == WAVE_SINE)
                        w_next = sine_val;
                    else if (a1 && job_reg.wave == WAVE_SAW)
                        w_next = w_reg - corr(div_quo, g1);
                    else if (a1 && job_reg.wave == WAVE_SQUARE)
                        w_next = w_reg + corr(div_quo, g1);
                    state_next = ST_DIV2;
                    div_start  = 1'b1;
                end
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    if (a2 && job_reg.wave == WAVE_SQUARE)
                        w_next = w_reg - corr(div_quo, g2);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Wait for the output register to free up.
                if (!out_full_reg || pop)
                begin
                    if (yq > PBits'(WOne - 1))
                        out_next = OutBits'(WOne - 1);
                    else if (yq < -PBits'(WOne))
                        out_next = OutBits'(-WOne);
                    else
                        out_next = OutBits'(yq);
                    out_full_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_full_reg    <= 1'b0;
            start_pulse_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            out_full_reg    <= out_full_next;
            start_pulse_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= job;
        w_reg   <= w_next;
        out_reg <= out_next;
    end

    `ASSERT_IMPL(a_ready_idle, clk, rst_n, job_ready, state_reg == ST_IDLE)
    `ASSERT_NEXT(a_load_div, clk, rst_n, load, state_reg == ST_DIV1)
    `ASSERT_NEXT(a_out_fill, clk, rst_n, state_reg == ST_OUT && (!out_full_reg || pop),
                 out_full_reg)
endmodule

/* hdl/polyblep_oscillator.sv */
// PolyBLEP oscillator: one saturated sample per accepted tick.
// Each result passes two serial divisions in the back part, then the gain stage.
// The back part works on one item at a time; the queue holds further accepted ticks.
// Reset: rst_n async active low clears phase, waveform (sine), queue, output flag.
// Depends on pbo_pkg, pbo_front, pbo_queue, pbo_back.
module polyblep_oscillator
    import pbo_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      waveform_we,
    input  logic [1:0]                waveform,
    input  logic                      push,
    output logic                      full,
    input  logic [PhaseBits-1:0]      phase_step,
    input  logic [GainBits-1:0]       gain,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [OutBits-1:0] sample
);
    wave_t wave_reg;
    logic  fq_valid, fq_ready, qb_valid, qb_ready;
    job_t  fq_job, qb_job;

    // Hold waveform register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wave_reg <= WAVE_SINE;
        else if (waveform_we)
            wave_reg <= wave_t'(waveform);
    end

    pbo_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .phase_step (phase_step),
        .gain       (gain),
        .wave       (wave_reg),
        .job_valid  (fq_valid),
        .job_ready  (fq_ready),
        .job        (fq_job)
    );

    pbo_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_job)
    );

    pbo_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .empty     (empty),
        .pop       (pop),
        .sample    (sample)
    );
endmodule
